// ----- rtl/ptq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared widths, types and lane indexes for the point in triangle or quad test.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int NUM_EDGES = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef enum logic {
    CMD_TRI  = 1'b0,
    CMD_QUAD = 1'b1
  } cmd_t;

  localparam int EDGE_A_AREA = 0;
  localparam int EDGE_A_E0   = 1;
  localparam int EDGE_A_E1   = 2;
  localparam int EDGE_A_E2   = 3;
  localparam int EDGE_B_AREA = 4;
  localparam int EDGE_B_E0   = 5;
  localparam int EDGE_B_E1   = 6;
  localparam int EDGE_B_E2   = 7;

endpackage

// ----- rtl/ptq_cross_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_cross_lane
// Three-stage sign of the cross product (b - a) x (p - a): differences,
// products, then an exact compare of the two products.
// ----------------------------------------------------------------------------
module ptq_cross_lane (
  input  logic              clk,
  input  ptq_pkg::stage_en_t en,
  input  ptq_pkg::coord_t   a_x,
  input  ptq_pkg::coord_t   a_y,
  input  ptq_pkg::coord_t   b_x,
  input  ptq_pkg::coord_t   b_y,
  input  ptq_pkg::coord_t   p_x,
  input  ptq_pkg::coord_t   p_y,
  output ptq_pkg::sign_t    sign_o
);

  ptq_pkg::diff_t dxb_r, dyp_r, dyb_r, dxp_r;
  ptq_pkg::diff_t dxb_nxt, dyp_nxt, dyb_nxt, dxp_nxt;
  ptq_pkg::prod_t pl_r, pr_r, pl_nxt, pr_nxt;
  logic signed [ptq_pkg::PROD_W:0] dif;
  ptq_pkg::sign_t sign_r, sign_nxt;

  always_comb begin
    dxb_nxt = ptq_pkg::diff_t'(b_x) - ptq_pkg::diff_t'(a_x);
    dyp_nxt = ptq_pkg::diff_t'(p_y) - ptq_pkg::diff_t'(a_y);
    dyb_nxt = ptq_pkg::diff_t'(b_y) - ptq_pkg::diff_t'(a_y);
    dxp_nxt = ptq_pkg::diff_t'(p_x) - ptq_pkg::diff_t'(a_x);
    pl_nxt  = ptq_pkg::prod_t'(dxb_r) * ptq_pkg::prod_t'(dyp_r);
    pr_nxt  = ptq_pkg::prod_t'(dyb_r) * ptq_pkg::prod_t'(dxp_r);
    dif     = {pl_r[ptq_pkg::PROD_W-1], pl_r} - {pr_r[ptq_pkg::PROD_W-1], pr_r};
    sign_nxt.neg  = dif[ptq_pkg::PROD_W];
    sign_nxt.zero = (pl_r == pr_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dxb_r <= dxb_nxt;
      dyp_r <= dyp_nxt;
      dyb_r <= dyb_nxt;
      dxp_r <= dxp_nxt;
    end
    if (en.s2) begin
      pl_r <= pl_nxt;
      pr_r <= pr_nxt;
    end
    if (en.s3) begin
      sign_r <= sign_nxt;
    end
  end

  assign sign_o = sign_r;

endmodule

// ----- rtl/ptq_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_decide
// Combines the edge and area signs of both triangles into the final verdict.
// ----------------------------------------------------------------------------
module ptq_decide (
  input  ptq_pkg::cmd_t  command,
  input  ptq_pkg::sign_t signs [ptq_pkg::NUM_EDGES],
  output logic           inside_res,
  output logic           matched_half
);

  logic in_a, in_b;

  function automatic logic tri_hit(ptq_pkg::sign_t area, ptq_pkg::sign_t e0,
                                   ptq_pkg::sign_t e1, ptq_pkg::sign_t e2);
    logic all_le, all_ge;
    all_le = (e0.neg | e0.zero) & (e1.neg | e1.zero) & (e2.neg | e2.zero);
    all_ge = !e0.neg & !e1.neg & !e2.neg;
    return !area.zero & (area.neg ? all_le : all_ge);
  endfunction

  always_comb begin
    in_a = tri_hit(signs[ptq_pkg::EDGE_A_AREA], signs[ptq_pkg::EDGE_A_E0],
                   signs[ptq_pkg::EDGE_A_E1], signs[ptq_pkg::EDGE_A_E2]);
    in_b = (command == ptq_pkg::CMD_QUAD) &
           tri_hit(signs[ptq_pkg::EDGE_B_AREA], signs[ptq_pkg::EDGE_B_E0],
                   signs[ptq_pkg::EDGE_B_E1], signs[ptq_pkg::EDGE_B_E2]);
    inside_res   = in_a | in_b;
    matched_half = !in_a & in_b;
  end

endmodule

// ----- rtl/point_in_triangle_or_quad_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_or_quad_test
// Throughput: one beat per cycle while out_ready does not stall the pipe;
// eight cross-product lanes, each with two registered 33x33 multipliers,
// run in parallel, and the pipeline has four register stages.
// Reset clears the stage valid bits and out_valid; payload registers are not
// reset. Each stage advances independently, so bubbles close up under stalls.
// ----------------------------------------------------------------------------
module point_in_triangle_or_quad_test (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_command,
  input  ptq_pkg::coord_t in_vertex0_x,
  input  ptq_pkg::coord_t in_vertex0_y,
  input  ptq_pkg::coord_t in_vertex1_x,
  input  ptq_pkg::coord_t in_vertex1_y,
  input  ptq_pkg::coord_t in_vertex2_x,
  input  ptq_pkg::coord_t in_vertex2_y,
  input  ptq_pkg::coord_t in_vertex3_x,
  input  ptq_pkg::coord_t in_vertex3_y,
  input  ptq_pkg::coord_t in_point_x,
  input  ptq_pkg::coord_t in_point_y,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_inside_res,
  output logic            out_matched_half
);

  logic v1_r, v2_r, v3_r, out_valid_r;
  ptq_pkg::cmd_t cmd1_r, cmd2_r, cmd3_r;
  logic r1, r2, r3, r4;
  ptq_pkg::stage_en_t en;
  ptq_pkg::coord_t ax [ptq_pkg::NUM_EDGES];
  ptq_pkg::coord_t ay [ptq_pkg::NUM_EDGES];
  ptq_pkg::coord_t bx [ptq_pkg::NUM_EDGES];
  ptq_pkg::coord_t by [ptq_pkg::NUM_EDGES];
  ptq_pkg::coord_t px [ptq_pkg::NUM_EDGES];
  ptq_pkg::coord_t py [ptq_pkg::NUM_EDGES];
  ptq_pkg::sign_t  signs [ptq_pkg::NUM_EDGES];
  logic inside_nxt, half_nxt;
  logic inside_r, half_r;

  assign r4       = !out_valid_r || out_ready;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;
  assign en.s1    = r1;
  assign en.s2    = r2;
  assign en.s3    = r3;

  always_comb begin
    for (int i = 0; i < ptq_pkg::NUM_EDGES; i++) begin
      px[i] = in_point_x;
      py[i] = in_point_y;
    end
    ax[ptq_pkg::EDGE_A_AREA] = in_vertex0_x;  ay[ptq_pkg::EDGE_A_AREA] = in_vertex0_y;
    bx[ptq_pkg::EDGE_A_AREA] = in_vertex1_x;  by[ptq_pkg::EDGE_A_AREA] = in_vertex1_y;
    px[ptq_pkg::EDGE_A_AREA] = in_vertex2_x;  py[ptq_pkg::EDGE_A_AREA] = in_vertex2_y;
    ax[ptq_pkg::EDGE_A_E0]   = in_vertex0_x;  ay[ptq_pkg::EDGE_A_E0]   = in_vertex0_y;
    bx[ptq_pkg::EDGE_A_E0]   = in_vertex1_x;  by[ptq_pkg::EDGE_A_E0]   = in_vertex1_y;
    ax[ptq_pkg::EDGE_A_E1]   = in_vertex1_x;  ay[ptq_pkg::EDGE_A_E1]   = in_vertex1_y;
    bx[ptq_pkg::EDGE_A_E1]   = in_vertex2_x;  by[ptq_pkg::EDGE_A_E1]   = in_vertex2_y;
    ax[ptq_pkg::EDGE_A_E2]   = in_vertex2_x;  ay[ptq_pkg::EDGE_A_E2]   = in_vertex2_y;
    bx[ptq_pkg::EDGE_A_E2]   = in_vertex0_x;  by[ptq_pkg::EDGE_A_E2]   = in_vertex0_y;
    ax[ptq_pkg::EDGE_B_AREA] = in_vertex1_x;  ay[ptq_pkg::EDGE_B_AREA] = in_vertex1_y;
    bx[ptq_pkg::EDGE_B_AREA] = in_vertex3_x;  by[ptq_pkg::EDGE_B_AREA] = in_vertex3_y;
    px[ptq_pkg::EDGE_B_AREA] = in_vertex2_x;  py[ptq_pkg::EDGE_B_AREA] = in_vertex2_y;
    ax[ptq_pkg::EDGE_B_E0]   = in_vertex1_x;  ay[ptq_pkg::EDGE_B_E0]   = in_vertex1_y;
    bx[ptq_pkg::EDGE_B_E0]   = in_vertex3_x;  by[ptq_pkg::EDGE_B_E0]   = in_vertex3_y;
    ax[ptq_pkg::EDGE_B_E1]   = in_vertex3_x;  ay[ptq_pkg::EDGE_B_E1]   = in_vertex3_y;
    bx[ptq_pkg::EDGE_B_E1]   = in_vertex2_x;  by[ptq_pkg::EDGE_B_E1]   = in_vertex2_y;
    ax[ptq_pkg::EDGE_B_E2]   = in_vertex2_x;  ay[ptq_pkg::EDGE_B_E2]   = in_vertex2_y;
    bx[ptq_pkg::EDGE_B_E2]   = in_vertex1_x;  by[ptq_pkg::EDGE_B_E2]   = in_vertex1_y;
  end

  for (genvar g = 0; g < ptq_pkg::NUM_EDGES; g++) begin : g_lane
    ptq_cross_lane u_lane (
      .clk    (clk),
      .en     (en),
      .a_x    (ax[g]),
      .a_y    (ay[g]),
      .b_x    (bx[g]),
      .b_y    (by[g]),
      .p_x    (px[g]),
      .p_y    (py[g]),
      .sign_o (signs[g])
    );
  end

  ptq_decide u_decide (
    .command      (cmd3_r),
    .signs        (signs),
    .inside_res   (inside_nxt),
    .matched_half (half_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (r1) begin
        v1_r <= in_valid;
      end
      if (r2) begin
        v2_r <= v1_r;
      end
      if (r3) begin
        v3_r <= v2_r;
      end
      if (r4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      cmd1_r <= ptq_pkg::cmd_t'(in_command);
    end
    if (r2) begin
      cmd2_r <= cmd1_r;
    end
    if (r3) begin
      cmd3_r <= cmd2_r;
    end
    if (r4) begin
      inside_r <= inside_nxt;
      half_r   <= half_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = inside_r;
  assign out_matched_half = half_r;

  a_half_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!half_r || inside_r))
    else $error("matched half set on an outside result");

  a_tri_no_half: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && r4 && (cmd3_r == ptq_pkg::CMD_TRI)) |=> !half_r)
    else $error("triangle beat reported the second half");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted beat did not enter the first stage");

  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result beat appeared without a beat in the last stage");

endmodule

// ----- verif/tb_point_in_triangle_or_quad_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_triangle_or_quad_test
// Self-checking bench for the point in triangle or quad test. A short list of
// directed shapes covers unit triangles, both windings, points on vertices and
// edges, degenerate and collinear triangles, the quad diagonal overlap and the
// coordinate extremes. Random shapes follow: mostly small well-formed triangles
// and quads around random centers, boundary points, degenerate shapes and raw
// full-range noise. Typed rows carry their expectation; other accepted beats
// go through an exact cross-product predictor. Each result beat is checked
// against the oldest expectation; both sides idle and stall at random in phases.
// ----------------------------------------------------------------------------
module tb_point_in_triangle_or_quad_test;

  localparam int              CLK_HALF       = 2;
  localparam int              RESET_CYCLES   = 10;
  localparam int              ITEMS_PER_PASS = 110;
  localparam int              DRAIN_CYCLES   = 12;
  localparam int              STUCK_LIMIT    = 4000;
  localparam int              NUM_ROWS       = 22;
  localparam int              PEND_DEPTH     = 64;
  localparam ptq_pkg::coord_t C_MAX          = 32'sh7FFF_FFFF;
  localparam ptq_pkg::coord_t C_MIN          = 32'sh8000_0000;
  localparam ptq_pkg::coord_t C_ONE          = 32'sh0001_0000;
  localparam ptq_pkg::coord_t C_HALF         = 32'sh0000_8000;
  localparam ptq_pkg::coord_t C_QTR          = 32'sh0000_4000;
  localparam ptq_pkg::coord_t C_3QTR         = 32'sh0000_C000;
  localparam ptq_pkg::coord_t C_TWO          = 32'sh0002_0000;

  typedef struct {
    ptq_pkg::cmd_t   cmd;
    ptq_pkg::coord_t v0x, v0y, v1x, v1y, v2x, v2y, v3x, v3y, px, py;
    bit              typed;
    bit              exp_inside;
    bit              exp_half;
  } shape_beat_t;

  typedef struct {
    bit hit_in;
    bit half;
  } hit_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready;
  logic        out_inside_res;
  logic        out_matched_half;
  shape_beat_t beat_drv;

  hit_t        pending_hits[PEND_DEPTH];
  int          pend_wr;
  int          pend_rd;
  int          error_count;
  int          stuck_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  shape_beat_t stim_rows[NUM_ROWS];

  point_in_triangle_or_quad_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (beat_drv.cmd),
    .in_vertex0_x     (beat_drv.v0x),
    .in_vertex0_y     (beat_drv.v0y),
    .in_vertex1_x     (beat_drv.v1x),
    .in_vertex1_y     (beat_drv.v1y),
    .in_vertex2_x     (beat_drv.v2x),
    .in_vertex2_y     (beat_drv.v2y),
    .in_vertex3_x     (beat_drv.v3x),
    .in_vertex3_y     (beat_drv.v3y),
    .in_point_x       (beat_drv.px),
    .in_point_y       (beat_drv.py),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inside_res   (out_inside_res),
    .out_matched_half (out_matched_half)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Sign of (b - a) x (p - a), exact on 33-bit differences and 66-bit products.
  function automatic int cross_sign(ptq_pkg::coord_t ax, ptq_pkg::coord_t ay,
                                    ptq_pkg::coord_t bx, ptq_pkg::coord_t by,
                                    ptq_pkg::coord_t px, ptq_pkg::coord_t py);
    ptq_pkg::diff_t dbx, dby, dpx, dpy;
    ptq_pkg::prod_t lhs, rhs;
    dbx = ptq_pkg::diff_t'(bx) - ptq_pkg::diff_t'(ax);
    dby = ptq_pkg::diff_t'(by) - ptq_pkg::diff_t'(ay);
    dpx = ptq_pkg::diff_t'(px) - ptq_pkg::diff_t'(ax);
    dpy = ptq_pkg::diff_t'(py) - ptq_pkg::diff_t'(ay);
    lhs = ptq_pkg::prod_t'(dbx) * ptq_pkg::prod_t'(dpy);
    rhs = ptq_pkg::prod_t'(dby) * ptq_pkg::prod_t'(dpx);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic bit tri_contains(ptq_pkg::coord_t ax, ptq_pkg::coord_t ay,
                                      ptq_pkg::coord_t bx, ptq_pkg::coord_t by,
                                      ptq_pkg::coord_t cx, ptq_pkg::coord_t cy,
                                      ptq_pkg::coord_t px, ptq_pkg::coord_t py);
    int area, e0, e1, e2;
    area = cross_sign(ax, ay, bx, by, cx, cy);
    e0   = cross_sign(ax, ay, bx, by, px, py);
    e1   = cross_sign(bx, by, cx, cy, px, py);
    e2   = cross_sign(cx, cy, ax, ay, px, py);
    if (area > 0) return (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
    if (area < 0) return (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
    return 1'b0;
  endfunction

  function automatic hit_t predict_hit(shape_beat_t b);
    hit_t h;
    h.hit_in = 1'b0;
    h.half   = 1'b0;
    if (tri_contains(b.v0x, b.v0y, b.v1x, b.v1y, b.v2x, b.v2y, b.px, b.py)) begin
      h.hit_in = 1'b1;
    end else if (b.cmd == ptq_pkg::CMD_QUAD &&
                 tri_contains(b.v1x, b.v1y, b.v3x, b.v3y, b.v2x, b.v2y, b.px, b.py)) begin
      h.hit_in = 1'b1;
      h.half   = 1'b1;
    end
    return h;
  endfunction

  function automatic int rand_off(int s);
    return int'($urandom_range(2 * s)) - s;
  endfunction

  function automatic shape_beat_t rand_shape();
    shape_beat_t b;
    int kind, cx, cy, s, n, j;
    int dx1, dy1, dx2, dy2, dx3, dy3;
    kind         = $urandom_range(99);
    b.cmd        = ptq_pkg::cmd_t'($urandom_range(1));
    b.typed      = 1'b0;
    b.exp_inside = 1'b0;
    b.exp_half   = 1'b0;
    b.v0x = $urandom(); b.v0y = $urandom(); b.v1x = $urandom(); b.v1y = $urandom();
    b.v2x = $urandom(); b.v2y = $urandom(); b.v3x = $urandom(); b.v3y = $urandom();
    b.px  = $urandom(); b.py  = $urandom();
    cx  = int'($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
    cy  = int'($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
    s   = 1 << $urandom_range(0, 12);
    n   = $urandom_range(1, 8);
    j   = $urandom_range(0, n);
    dx1 = rand_off(s); dy1 = rand_off(s);
    dx2 = rand_off(s); dy2 = rand_off(s);
    dx3 = rand_off(s); dy3 = rand_off(s);
    if (kind >= 15 && kind < 75) begin
      s = 1 << $urandom_range(4, 20);
      b.v0x = cx + rand_off(s); b.v0y = cy + rand_off(s);
      b.v1x = cx + rand_off(s); b.v1y = cy + rand_off(s);
      b.v2x = cx + rand_off(s); b.v2y = cy + rand_off(s);
      b.v3x = cx + rand_off(s); b.v3y = cy + rand_off(s);
      b.px  = cx + rand_off(s); b.py  = cy + rand_off(s);
      if ($urandom_range(1)) begin
        b.v3x = b.v1x + b.v2x - b.v0x;
        b.v3y = b.v1y + b.v2y - b.v0y;
      end
    end else if (kind >= 75 && kind < 90) begin
      b.v0x = cx;            b.v0y = cy;
      b.v1x = cx + n * dx1;  b.v1y = cy + n * dy1;
      b.v2x = cx + n * dx2;  b.v2y = cy + n * dy2;
      b.v3x = b.v1x + n * dx3;
      b.v3y = b.v1y + n * dy3;
      if ($urandom_range(1)) begin
        b.px = cx + j * dx1;
        b.py = cy + j * dy1;
      end else begin
        b.px = b.v1x + j * dx3;
        b.py = b.v1y + j * dy3;
      end
    end else if (kind >= 90) begin
      b.v0x = cx;            b.v0y = cy;
      b.v1x = cx + dx1;      b.v1y = cy + dy1;
      b.v2x = cx + n * dx1;  b.v2y = cy + n * dy1;
      b.v3x = cx + dx2;      b.v3y = cy + dy2;
      if ($urandom_range(1)) begin
        b.px = cx + j * dx1;
        b.py = cy + j * dy1;
      end else begin
        b.px = cx + rand_off(s);
        b.py = cy + rand_off(s);
      end
    end
    return b;
  endfunction

  task automatic send_beat(input shape_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    beat_drv <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    hit_t h;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (beat_drv.typed) begin
          h.hit_in = beat_drv.exp_inside;
          h.half   = beat_drv.exp_half;
        end else begin
          h = predict_hit(beat_drv);
        end
        pending_hits[pend_wr % PEND_DEPTH] = h;
        pend_wr++;
      end
      if (out_valid && out_ready) begin
        if (pend_wr == pend_rd) begin
          $display("%0t: unexpected result beat: expected none, actual inside=%0b half=%0b",
                   $time, out_inside_res, out_matched_half);
          error_count++;
        end else begin
          h = pending_hits[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (out_inside_res !== h.hit_in) begin
            $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                     $time, h.hit_in, out_inside_res);
            error_count++;
          end
          if (out_matched_half !== h.half) begin
            $display("%0t: matched_half mismatch: expected %0b, actual %0b",
                     $time, h.half, out_matched_half);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    stim_rows = '{
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, 0, 0, C_ONE, 0, 0, C_QTR, C_QTR, 1, 1, 0},
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, 0, 0, C_ONE, 0, 0, 0, 0, 1, 1, 0},
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, 0, 0, C_ONE, 0, 0, C_HALF, C_HALF, 1, 1, 0},
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, 0, 0, C_ONE, 0, 0, C_ONE, C_ONE, 1, 0, 0},
      '{ptq_pkg::CMD_TRI,  0, 0, 0, C_ONE, C_ONE, 0, 0, 0, C_QTR, C_QTR, 1, 1, 0},
      '{ptq_pkg::CMD_TRI,  C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, 0, 0, C_ONE, C_ONE,
        1, 0, 0},
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, C_ONE, C_TWO, C_TWO, 0, 0, C_ONE, C_ONE, 1, 0, 0},
      '{ptq_pkg::CMD_QUAD, 0, 0, C_ONE, 0, 0, C_ONE, C_ONE, C_ONE, C_3QTR, C_3QTR,
        1, 1, 1},
      '{ptq_pkg::CMD_TRI,  0, 0, C_ONE, 0, 0, C_ONE, C_ONE, C_ONE, C_3QTR, C_3QTR,
        1, 0, 0},
      '{ptq_pkg::CMD_QUAD, 0, 0, C_ONE, 0, 0, C_ONE, C_ONE, C_ONE, C_HALF, C_HALF, 1, 1, 0},
      '{ptq_pkg::CMD_QUAD, 0, 0, C_ONE, 0, 0, C_ONE, C_ONE, C_ONE, C_TWO, C_TWO, 1, 0, 0},
      '{ptq_pkg::CMD_QUAD, 0, 0, 0, 0, 0, C_ONE, C_ONE, C_ONE, C_QTR, C_3QTR, 1, 1, 1},
      '{ptq_pkg::CMD_TRI,  C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, C_MIN, C_MIN,
        1, 1, 0},
      '{ptq_pkg::CMD_TRI,  C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, C_MAX, C_MAX,
        1, 0, 0},
      '{ptq_pkg::CMD_QUAD, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
        C_MAX, C_MAX, 1, 1, 1},
      '{ptq_pkg::CMD_TRI,  C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0, 0, 0, 0},
      '{ptq_pkg::CMD_TRI,  C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
        C_MAX, C_MAX, 1, 0, 0},
      '{ptq_pkg::CMD_QUAD, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
        C_MIN, C_MIN, 1, 0, 0},
      '{ptq_pkg::CMD_TRI,  C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, C_MAX, C_MIN,
        1, 1, 0},
      '{ptq_pkg::CMD_QUAD, C_MAX, C_MIN, C_MIN, C_MAX, -1, -1, C_MIN, C_MIN, -1, -1,
        0, 0, 0},
      '{ptq_pkg::CMD_TRI,  C_MIN, 0, C_MAX, 0, 0, C_MAX, C_MAX, C_MIN, 0, 1, 0, 0, 0},
      '{ptq_pkg::CMD_QUAD, 0, 0, C_TWO, 0, C_ONE, C_QTR, C_TWO, C_TWO, C_ONE, C_HALF,
        0, 0, 0}
    };

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    out_ready      <= 1'b0;
    beat_drv       <= stim_rows[0];
    pend_wr        = 0;
    pend_rd        = 0;
    error_count    = 0;
    stuck_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_beat(stim_rows[i]);
    drain_results();

    for (int pass_idx = 0; pass_idx < 4; pass_idx++) begin
      case (pass_idx)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      repeat (ITEMS_PER_PASS) send_beat(rand_shape());
      if (pass_idx == 1) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pend_wr == pend_rd) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ptq_pkg.sv
rtl/ptq_cross_lane.sv
rtl/ptq_decide.sv
rtl/point_in_triangle_or_quad_test.sv
verif/tb_point_in_triangle_or_quad_test.sv
